// File: src/svkt_pkg.sv
// svkt_pkg: shared types and constants for the sorted voxel key table
// depends on: nothing
package svkt_pkg;

    localparam int unsigned FIELD_BITS = 10;
    localparam int unsigned KEY_BITS   = 3 * FIELD_BITS;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CHECK  = 2'd2,
        MODE_SIDES  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [FIELD_BITS-1:0] x_coord;
        logic [FIELD_BITS-1:0] y_coord;
        logic [FIELD_BITS-1:0] z_coord;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] sides;
        logic       status;
    } rsp_t;

endpackage

// File: src/svkt_mem.sv
// svkt_mem: entry memory (key and active mark), one write and one registered read port
// depends on: nothing
module svkt_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // synchronous write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/sorted_voxel_key_table.sv
// sorted_voxel_key_table: sorted morton key table with removal marks
// insert/remove/check: setup, binary search of p probes, read and compare of the found slot, finish,
// then the result strobe; p = probes of the binary search, at most ceil(log2(entries + 1)), 11 at full depth
// visible sides: six such searches, one per neighbor (an off-grid neighbor skips its search), then finish
// an insert that opens a slot first shifts every later entry up one slot; busy covers the strobe cycle
// reset clears the entry count and control state; memory needs no clearing; no output stall
module sorted_voxel_key_table
    import svkt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned COORD_BITS  = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned KW  = 3 * COORD_BITS;
    localparam int unsigned MW  = KW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_PROBE, S_WAIT, S_CMP, S_NEXT, S_ACT,
        S_SHRD, S_SHWR, S_FIN
    } state_t;

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic [2:0]         dir_reg;
    logic [KW-1:0]      key_reg;
    logic               skip_reg;
    logic [CW-1:0]      lo_reg, hi_reg, cnt_reg, sh_reg;
    logic [5:0]         sides_reg;
    logic               hit_reg, status_reg, done_reg;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [MW-1:0]      wdata, rdata;

    svkt_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(MW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // morton interleave
    function automatic logic [KW-1:0] morton(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] z
    );
        logic [KW-1:0] k;
        k = '0;
        for (int i = 0; i < int'(COORD_BITS); i++)
        begin
            k[3*i]   = x[i];
            k[3*i+1] = y[i];
            k[3*i+2] = z[i];
        end
        return k;
    endfunction

    localparam logic [COORD_BITS-1:0] CMAX = '1;

    // neighbor key for the current side and edge check
    logic [COORD_BITS-1:0] nx, ny, nz;
    logic                  nskip;
    always_comb
    begin
        nx = x_reg;
        ny = y_reg;
        nz = z_reg;
        nskip = 1'b0;
        unique case (dir_reg)
            3'd0:
            begin
                ny = y_reg + 1'b1;
                nskip = (y_reg == CMAX);
            end
            3'd1:
            begin
                nz = z_reg + 1'b1;
                nskip = (z_reg == CMAX);
            end
            3'd2:
            begin
                nx = x_reg + 1'b1;
                nskip = (x_reg == CMAX);
            end
            3'd3:
            begin
                nx = x_reg - 1'b1;
                nskip = (x_reg == '0);
            end
            3'd4:
            begin
                nz = z_reg - 1'b1;
                nskip = (z_reg == '0);
            end
            default:
            begin
                ny = y_reg - 1'b1;
                nskip = (y_reg == '0);
            end
        endcase
    end

    // probe midpoint and comparisons
    logic [CW-1:0] mid;
    logic [KW-1:0] rkey;
    logic          ract, found, in_range;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rkey     = rdata[KW-1:0];
    assign ract     = rdata[KW];
    assign in_range = (lo_reg < cnt_reg);
    assign found    = (rkey == key_reg);

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = lo_reg[AW-1:0];
        wdata = {1'b1, key_reg};
        raddr = mid[AW-1:0];
        if (state_reg == S_PROBE)
        begin
            raddr = mid[AW-1:0];
        end
        else if (state_reg == S_ACT || state_reg == S_SHRD)
        begin
            raddr = (state_reg == S_SHRD) ? AW'(sh_reg - 1'b1) : lo_reg[AW-1:0];
        end
        if (state_reg == S_SHWR)
        begin
            we    = 1'b1;
            waddr = sh_reg[AW-1:0];
            wdata = rdata;
        end
        else if (state_reg == S_CMP && in_range && found && mode_reg == MODE_REMOVE)
        begin
            we    = 1'b1;
            wdata = {1'b0, key_reg};
        end
        else if (state_reg == S_CMP && mode_reg == MODE_INSERT && in_range
                 && (found || !ract))
        begin
            we = 1'b1;
        end
        else if (state_reg == S_FIN && mode_reg == MODE_INSERT && hit_reg && skip_reg)
        begin
            we = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            status_reg <= 1'b0;
            sides_reg  <= '0;
            mode_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            dir_reg    <= '0;
            key_reg    <= '0;
            skip_reg   <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            sh_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        mode_reg   <= cmd.mode;
                        x_reg      <= COORD_BITS'(cmd.x_coord);
                        y_reg      <= COORD_BITS'(cmd.y_coord);
                        z_reg      <= COORD_BITS'(cmd.z_coord);
                        dir_reg    <= '0;
                        hit_reg    <= 1'b0;
                        status_reg <= 1'b0;
                        sides_reg  <= 6'h3f;
                        state_reg  <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    if (mode_reg == MODE_SIDES)
                    begin
                        key_reg  <= morton(nx, ny, nz);
                        skip_reg <= nskip;
                    end
                    else
                    begin
                        key_reg  <= morton(x_reg, y_reg, z_reg);
                        skip_reg <= 1'b0;
                    end
                    lo_reg    <= '0;
                    hi_reg    <= cnt_reg;
                    state_reg <= S_PROBE;
                end
                S_PROBE:
                begin
                    if (skip_reg)
                        state_reg <= S_NEXT;
                    else if (lo_reg < hi_reg)
                        state_reg <= S_WAIT;
                    else
                        state_reg <= S_ACT;
                end
                S_WAIT:
                begin
                    if (rkey < key_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                    state_reg <= S_PROBE;
                end
                S_ACT:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    priority case (mode_reg)
                        MODE_INSERT:
                        begin
                            if (in_range && (found || !ract))
                            begin
                                hit_reg   <= 1'b1;
                                state_reg <= S_FIN;
                            end
                            else if (cnt_reg >= CW'(TABLE_DEPTH))
                            begin
                                status_reg <= 1'b1;
                                state_reg  <= S_FIN;
                            end
                            else
                            begin
                                sh_reg    <= cnt_reg;
                                hit_reg   <= 1'b1;
                                skip_reg  <= 1'b1;
                                state_reg <= (cnt_reg > lo_reg) ? S_SHRD : S_FIN;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            hit_reg   <= in_range && found;
                            state_reg <= S_FIN;
                        end
                        MODE_CHECK:
                        begin
                            hit_reg   <= in_range && found && ract;
                            state_reg <= S_FIN;
                        end
                        default:
                        begin
                            if (in_range && found && ract)
                                sides_reg[dir_reg] <= 1'b0;
                            state_reg <= S_NEXT;
                        end
                    endcase
                end
                S_NEXT:
                begin
                    if (dir_reg == 3'd5)
                        state_reg <= S_FIN;
                    else
                    begin
                        dir_reg   <= dir_reg + 1'b1;
                        state_reg <= S_SETUP;
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    sh_reg    <= sh_reg - 1'b1;
                    state_reg <= ((sh_reg - 1'b1) > lo_reg) ? S_SHRD : S_FIN;
                end
                default:
                begin
                    // S_FIN: count grows when a slot was opened
                    if (mode_reg == MODE_INSERT && hit_reg && skip_reg)
                        cnt_reg <= cnt_reg + 1'b1;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign busy       = (state_reg != S_IDLE) || done_reg;
    assign done       = done_reg;
    assign rsp.hit    = (mode_reg == MODE_SIDES) ? 1'b0 : hit_reg;
    assign rsp.sides  = (mode_reg == MODE_SIDES) ? sides_reg : 6'd0;
    assign rsp.status = status_reg;

endmodule

// File: src/svkt_checker.sv
// svkt_checker: port-level checks on the table's command handshake
// depends on: svkt_pkg, sorted_voxel_key_table
module svkt_checker
    import svkt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // a result needs an accepted transaction first
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside a transaction");

    // acceptance raises busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // full status never comes with a hit
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !(rsp.status && rsp.hit))
        else $error("full status with hit");

endmodule

bind sorted_voxel_key_table svkt_checker u_svkt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// File: sim/svkt_checker.sv
`timescale 1ns / 100ps
// svkt_scoreboard: watches command and response channels of the voxel key table,
// predicts each response from its own copy of the table and compares. depends on svkt_pkg
module svkt_scoreboard
    import svkt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned COORD_BITS  = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  cmd_t cmd,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending_count
);

    logic [KEY_BITS-1:0] shadow_keys [TABLE_DEPTH];
    logic                shadow_live [TABLE_DEPTH];
    int unsigned         shadow_used;
    rsp_t                expected_rsps[$];

    function automatic logic [KEY_BITS-1:0] interleave(input int unsigned x,
                                                       input int unsigned y,
                                                       input int unsigned z);
        logic [KEY_BITS-1:0] k;
        k = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            k[3*i]   = x[i];
            k[3*i+1] = y[i];
            k[3*i+2] = z[i];
        end
        return k;
    endfunction

    function automatic int unsigned lower_slot(input logic [KEY_BITS-1:0] k);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = shadow_used;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic is_live(input int x, input int y, input int z);
        int top;
        logic [KEY_BITS-1:0] k;
        int unsigned p;
        top = (1 << COORD_BITS) - 1;
        if (x < 0 || y < 0 || z < 0 || x > top || y > top || z > top) return 1'b0;
        k = interleave(x, y, z);
        p = lower_slot(k);
        return p < shadow_used && shadow_keys[p] == k && shadow_live[p];
    endfunction

    // apply one command to the shadow table and return its response
    function automatic rsp_t apply_cmd(input cmd_t c);
        rsp_t r;
        int x, y, z;
        int unsigned p;
        logic [KEY_BITS-1:0] k;
        r = '0;
        x = int'(c.x_coord) & ((1 << COORD_BITS) - 1);
        y = int'(c.y_coord) & ((1 << COORD_BITS) - 1);
        z = int'(c.z_coord) & ((1 << COORD_BITS) - 1);
        k = interleave(x, y, z);
        case (mode_t'(c.mode))
            MODE_INSERT:
            begin
                p = lower_slot(k);
                if (p < shadow_used && (shadow_keys[p] == k || !shadow_live[p]))
                begin
                    shadow_keys[p] = k;
                    shadow_live[p] = 1'b1;
                    r.hit = 1'b1;
                end
                else if (shadow_used >= TABLE_DEPTH)
                    r.status = 1'b1;
                else
                begin
                    for (int unsigned i = shadow_used; i > p; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_live[i] = shadow_live[i-1];
                    end
                    shadow_keys[p] = k;
                    shadow_live[p] = 1'b1;
                    shadow_used++;
                    r.hit = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                p = lower_slot(k);
                if (p < shadow_used && shadow_keys[p] == k)
                begin
                    shadow_live[p] = 1'b0;
                    r.hit = 1'b1;
                end
            end
            MODE_CHECK: r.hit = is_live(x, y, z);
            default:
            begin
                r.sides = 6'h3f;
                if (is_live(x, y + 1, z)) r.sides[0] = 1'b0;
                if (is_live(x, y, z + 1)) r.sides[1] = 1'b0;
                if (is_live(x + 1, y, z)) r.sides[2] = 1'b0;
                if (is_live(x - 1, y, z)) r.sides[3] = 1'b0;
                if (is_live(x, y, z - 1)) r.sides[4] = 1'b0;
                if (is_live(x, y - 1, z)) r.sides[5] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // predict on accepted transaction, compare on strobe
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            shadow_used = 0;
            expected_rsps.delete();
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response expected none actual %p", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.hit !== want.hit || rsp.sides !== want.sides
                        || rsp.status !== want.status)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_rsps = {expected_rsps, apply_cmd(cmd)};
            pending_count <= expected_rsps.size();
        end
    end

endmodule

// File: sim/tb_sorted_voxel_key_table.sv
`timescale 1ns / 100ps
// tb_sorted_voxel_key_table: stimulus and verdict for the voxel key table
// depends on svkt_pkg, sorted_voxel_key_table and svkt_scoreboard
module tb_sorted_voxel_key_table;
    import svkt_pkg::*;

    localparam int unsigned DEPTH = 1024;
    localparam int          CYCLE_LIMIT = 20_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy, done;
    rsp_t rsp;
    logic accepted_q = 1'b0;
    int   fail_count, pending_count;
    int   cycle_count = 0;
    int   idle_pct = 29;

    sorted_voxel_key_table #(.TABLE_DEPTH(DEPTH), .COORD_BITS(10)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .rsp(rsp)
    );

    svkt_scoreboard #(.TABLE_DEPTH(DEPTH), .COORD_BITS(10)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // acceptance seen at the rising edge
    always @(posedge clk)
    begin
        accepted_q <= start && !busy;
    end

    // one transaction: random gap, then hold start until accepted
    task automatic issue(input mode_t m, input int x, input int y, input int z);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) @(negedge clk);
        cmd <= '{mode: m, x_coord: x[9:0], y_coord: y[9:0], z_coord: z[9:0]};
        start <= 1'b1;
        @(negedge clk);
        while (!accepted_q) @(negedge clk);
        start <= 1'b0;
    endtask

    // random op on a voxel, mostly in a small cluster so neighbours and duplicates occur
    task automatic random_op(input int base);
        mode_t m;
        int x, y, z;
        m = mode_t'($urandom_range(3));
        if ($urandom_range(9) == 0)
        begin
            x = $urandom_range(1023);
            y = $urandom_range(1023);
            z = $urandom_range(1023);
        end
        else
        begin
            x = (base + $urandom_range(5)) & 1023;
            y = (base + $urandom_range(5)) & 1023;
            z = (base + $urandom_range(5)) & 1023;
        end
        issue(m, x, y, z);
    endtask

    initial
    begin
        int base;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, grid edges, duplicates, removal twice
        issue(MODE_CHECK, 0, 0, 0);
        issue(MODE_REMOVE, 0, 0, 0);
        issue(MODE_SIDES, 0, 0, 0);
        issue(MODE_INSERT, 0, 0, 0);
        issue(MODE_INSERT, 0, 0, 0);
        issue(MODE_INSERT, 1023, 1023, 1023);
        issue(MODE_SIDES, 1023, 1023, 1023);
        issue(MODE_INSERT, 1, 0, 0);
        issue(MODE_INSERT, 0, 1, 0);
        issue(MODE_INSERT, 0, 0, 1);
        issue(MODE_SIDES, 0, 0, 0);
        issue(MODE_SIDES, 1, 1, 1);
        issue(MODE_REMOVE, 1, 0, 0);
        issue(MODE_REMOVE, 1, 0, 0);
        issue(MODE_SIDES, 0, 0, 0);
        issue(MODE_CHECK, 1, 0, 0);
        issue(MODE_INSERT, 2, 0, 0);
        issue(MODE_INSERT, 1, 0, 0);
        issue(MODE_CHECK, 1023, 0, 1023);
        issue(MODE_SIDES, 1022, 1023, 1023);
        issue(MODE_REMOVE, 1023, 1023, 1023);
        issue(MODE_SIDES, 1022, 1023, 1023);

        // random phases with different sender idling
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 29 : (ph == 1) ? 52 : 0;
            for (int n = 0; n < 100; n++)
            begin
                if (n % 100 == 0) base = $urandom_range(1023);
                random_op(base);
            end
        end

        // fill the table to reach the full case, then probe it
        idle_pct = 0;
        for (int n = 0; n < 1100; n++)
            issue(MODE_INSERT, n & 1023, (n >> 10) & 1, 512);
        issue(MODE_REMOVE, 5, 0, 512);
        issue(MODE_INSERT, 5, 0, 512);
        issue(MODE_REMOVE, 7, 0, 512);
        issue(MODE_INSERT, 7, 0, 512);
        issue(MODE_INSERT, 3, 3, 3);
        issue(MODE_SIDES, 6, 0, 512);
        for (int n = 0; n < 150; n++) random_op(0);

        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
src/svkt_pkg.sv
src/svkt_mem.sv
src/sorted_voxel_key_table.sv
src/svkt_checker.sv
sim/svkt_checker.sv
sim/tb_sorted_voxel_key_table.sv
